// ----- hdl/mcwg_pkg.sv -----
// Shared types and constants for the multi-client watchdog gate.
package mcwg_pkg;

    localparam int CLIENTS  = 3;
    localparam int CLIENT_W = 2;
    localparam int TICK_W   = 32;
    localparam int PERIOD_W = 20;
    localparam int GRACE_W  = 31;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 5;
    localparam int REG_IDX_W = 3;

    localparam logic [TICK_W-1:0]   GRACE_SPLIT  = 32'h8000_0000;
    localparam logic [TICK_W-1:0]   DEADLINE_RST = 32'd1000;
    localparam logic [PERIOD_W-1:0] PERIOD_RST   = 20'd100;
    localparam logic [GRACE_W-1:0]  GRACE_RST    = 31'd5000;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_CHECKIN = 2'd1,
        CMD_SUSPEND = 2'd2,
        CMD_RESUME  = 2'd3
    } t_cmd;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_DEADLINE0    = 3'd0,
        REG_DEADLINE1    = 3'd1,
        REG_DEADLINE2    = 3'd2,
        REG_SWEEP_PERIOD = 3'd3,
        REG_BOOT_GRACE   = 3'd4
    } t_reg_idx;

    typedef struct packed {
        t_cmd                cmd;
        logic [CLIENT_W-1:0] client;
    } t_in_item;

    typedef struct packed {
        logic                swept;
        logic                pulse;
        logic                stall_event;
        logic                recover_event;
        logic                late_valid;
        logic [CLIENT_W-1:0] late_idx;
        logic [TICK_W-1:0]   late_by;
        logic                kicking;
    } t_out_item;

    typedef struct packed {
        logic [CLIENTS-1:0][TICK_W-1:0] deadline;
        logic [PERIOD_W-1:0]            sweep_period;
        logic [GRACE_W-1:0]             boot_grace;
    } t_cfg;

endpackage

// ----- hdl/multi_client_watchdog_gate_top.sv -----
// Top level of the multi-client watchdog gate: item pipeline and watchdog state.
//
// Items enter on the input channel (i_in_valid, o_in_ready, i_in_item): a tick, a
// check-in, a suspend or a resume for one of three clients. Every item yields
// exactly one result on the output channel (o_out_valid, i_out_ready,
// o_out_item), in order. Every sweep_period ticks a sweep checks each enabled
// client's elapsed time against its deadline and either pulses or reports the
// first late client, with stall and recovery edges flagged.
// An accepted item waits in the input register until its result is written into
// the result register. One item per cycle is sustained while i_out_ready stays
// high; the limit is the single pass from the input register through the
// per-client deadline subtractors and priority pick into the result register.
// When the receiver stalls, the result register holds its item and the input
// register takes one more item, after which o_in_ready drops.
// Reset is synchronous and active low: the tick count and sweep phase clear,
// all clients are enabled with a zero check-in time, pulsing is on, and the
// registers return to deadline 1000, sweep period 100 and boot grace 5000.
// The user must write registers over the APB-style port only while the block is idle; not enforced.
module multi_client_watchdog_gate_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  mcwg_pkg::t_in_item          i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output mcwg_pkg::t_out_item         o_out_item,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mcwg_pkg::ADDR_W-1:0] paddr,
    input  logic [mcwg_pkg::DATA_W-1:0] pwdata,
    output logic [mcwg_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import mcwg_pkg::*;

    t_cfg                w_cfg;

    logic                r_in_valid;
    t_in_item            r_in;
    logic                r_out_valid;
    t_out_item           r_out;
    t_out_item           n_out;
    logic                w_advance;

    // Tick count and sweep phase are kept one tick ahead; elapsed counts too.
    logic [TICK_W-1:0]   r_tick_nx;
    logic [TICK_W-1:0]   n_tick_nx;
    logic [PERIOD_W-1:0] r_phase_nx;
    logic [PERIOD_W-1:0] n_phase_nx;
    logic [TICK_W-1:0]   r_elapsed [CLIENTS];
    logic [TICK_W-1:0]   n_elapsed [CLIENTS];
    logic [CLIENTS-1:0]  r_enabled;
    logic [CLIENTS-1:0]  n_enabled;
    logic                r_pulsing;
    logic                n_pulsing;

    logic [TICK_W:0]     w_diff [CLIENTS];
    logic [CLIENTS-1:0]  w_late;
    logic [TICK_W-1:0]   w_grace_diff;
    logic                w_grace_open;
    logic                w_sweep;
    logic                w_found;
    logic [CLIENT_W-1:0] w_pick;
    logic [TICK_W-1:0]   w_by;

    mcwg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_advance   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign w_grace_diff = r_tick_nx - {1'b0, w_cfg.boot_grace};
    assign w_grace_open = w_grace_diff > GRACE_SPLIT;
    assign w_sweep      = r_phase_nx >= w_cfg.sweep_period;

    always_comb begin
        for (int i = 0; i < CLIENTS; i++) begin
            w_diff[i] = {1'b0, r_elapsed[i]} - {1'b0, w_cfg.deadline[i]};
            w_late[i] = r_enabled[i] && !w_diff[i][TICK_W];
        end
    end

    always_comb begin
        w_pick = '0;
        w_by   = '0;
        for (int i = CLIENTS - 1; i >= 0; i--) begin
            if (w_late[i]) begin
                w_pick = CLIENT_W'(i);
                w_by   = w_diff[i][TICK_W-1:0];
            end
        end
        w_found = (|w_late) && !w_grace_open;
    end

    always_comb begin
        n_tick_nx  = r_tick_nx;
        n_phase_nx = r_phase_nx;
        n_elapsed  = r_elapsed;
        n_enabled  = r_enabled;
        n_pulsing  = r_pulsing;
        n_out      = '0;
        case (r_in.cmd)
            CMD_TICK: begin
                n_tick_nx = r_tick_nx + 1'b1;
                for (int i = 0; i < CLIENTS; i++) begin
                    n_elapsed[i] = r_elapsed[i] + 1'b1;
                end
                if (w_sweep) begin
                    n_phase_nx  = PERIOD_W'(1);
                    n_out.swept = 1'b1;
                    if (w_found) begin
                        n_out.late_valid  = 1'b1;
                        n_out.late_idx    = w_pick;
                        n_out.late_by     = w_by;
                        n_out.stall_event = r_pulsing;
                        n_pulsing         = 1'b0;
                    end else begin
                        n_out.pulse         = 1'b1;
                        n_out.recover_event = !r_pulsing;
                        n_pulsing           = 1'b1;
                    end
                end else begin
                    n_phase_nx = r_phase_nx + 1'b1;
                end
            end
            default: begin
                for (int i = 0; i < CLIENTS; i++) begin
                    if (r_in.client == CLIENT_W'(i)) begin
                        if (r_in.cmd == CMD_CHECKIN || r_in.cmd == CMD_RESUME) begin
                            n_elapsed[i] = TICK_W'(1);
                        end
                        if (r_in.cmd == CMD_SUSPEND) begin
                            n_enabled[i] = 1'b0;
                        end
                        if (r_in.cmd == CMD_RESUME) begin
                            n_enabled[i] = 1'b1;
                        end
                    end
                end
            end
        endcase
        n_out.kicking = n_pulsing;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_nx  <= TICK_W'(1);
            r_phase_nx <= PERIOD_W'(1);
            for (int i = 0; i < CLIENTS; i++) begin
                r_elapsed[i] <= TICK_W'(1);
            end
            r_enabled <= '1;
            r_pulsing <= 1'b1;
        end else if (w_advance) begin
            r_tick_nx  <= n_tick_nx;
            r_phase_nx <= n_phase_nx;
            r_elapsed  <= n_elapsed;
            r_enabled  <= n_enabled;
            r_pulsing  <= n_pulsing;
        end
    end

    a_kicking_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> (r_out.kicking == r_pulsing))
        else $error("Result kicking differs from the pulse train state.");

    a_recover_only_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && n_out.recover_event) |-> !r_pulsing)
        else $error("Recovery flagged while already pulsing.");

    a_no_sweep_without_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in.cmd != CMD_TICK) |=> !r_out.swept)
        else $error("Sweep reported for an item that is not a tick.");

    a_phase_never_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |-> (r_phase_nx != '0))
        else $error("Sweep phase wrapped to zero.");

endmodule

// ----- hdl/mcwg_regs.sv -----
// Configuration register file behind the APB-style port.
module mcwg_regs (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [mcwg_pkg::ADDR_W-1:0] paddr,
    input  logic [mcwg_pkg::DATA_W-1:0] pwdata,
    output logic [mcwg_pkg::DATA_W-1:0] prdata,
    output logic                   pready,
    output mcwg_pkg::t_cfg         o_cfg
);
    import mcwg_pkg::*;

    t_cfg                 r_cfg;
    t_cfg                 n_cfg;
    logic [REG_IDX_W-1:0] w_idx;
    logic                 w_write;

    assign w_idx   = paddr[ADDR_W-1:2];
    assign w_write = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_write) begin
            unique case (w_idx)
                REG_DEADLINE0:    n_cfg.deadline[0] = pwdata[TICK_W-1:0];
                REG_DEADLINE1:    n_cfg.deadline[1] = pwdata[TICK_W-1:0];
                REG_DEADLINE2:    n_cfg.deadline[2] = pwdata[TICK_W-1:0];
                REG_SWEEP_PERIOD: n_cfg.sweep_period = pwdata[PERIOD_W-1:0];
                REG_BOOT_GRACE:   n_cfg.boot_grace = pwdata[GRACE_W-1:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_DEADLINE0:    prdata = r_cfg.deadline[0];
            REG_DEADLINE1:    prdata = r_cfg.deadline[1];
            REG_DEADLINE2:    prdata = r_cfg.deadline[2];
            REG_SWEEP_PERIOD: prdata = {{(DATA_W-PERIOD_W){1'b0}}, r_cfg.sweep_period};
            REG_BOOT_GRACE:   prdata = {{(DATA_W-GRACE_W){1'b0}}, r_cfg.boot_grace};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CLIENTS; i++) begin
                r_cfg.deadline[i] <= DEADLINE_RST;
            end
            r_cfg.sweep_period <= PERIOD_RST;
            r_cfg.boot_grace   <= GRACE_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the multi-client watchdog gate: random items, checked results.
module testbench;
    import mcwg_pkg::*;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    t_in_item            i_in_item = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    t_out_item           o_out_item;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    multi_client_watchdog_gate_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [TICK_W-1:0]   deadline_cfg [CLIENTS] = '{DEADLINE_RST, DEADLINE_RST, DEADLINE_RST};
    logic [PERIOD_W-1:0] period_cfg = PERIOD_RST;
    logic [GRACE_W-1:0]  grace_cfg = GRACE_RST;

    logic [TICK_W-1:0]   tick_count = '0;
    logic [PERIOD_W-1:0] sweep_phase = '0;
    logic [TICK_W-1:0]   last_checkin [CLIENTS] = '{'0, '0, '0};
    logic                client_on [CLIENTS] = '{1'b1, 1'b1, 1'b1};
    logic                pulsing = 1'b1;

    t_in_item  queued_cmds [$];
    t_out_item expected_gate_results [$];

    int send_gap = 0;
    int recv_gap = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatch_count = 0;
    int items_accepted = 0;
    int results_checked = 0;
    int settings_applied = 0;
    int sweep_count = 0;
    int stall_count = 0;
    int recover_count = 0;
    int ignored_count = 0;

    function automatic t_out_item next_gate_result(t_in_item it);
        t_out_item   res;
        logic [31:0] elapsed;
        logic        found;
        logic        grace_open;
        res = '0;
        found = 1'b0;
        if (it.cmd == CMD_TICK) begin
            tick_count = tick_count + 1;
            sweep_phase = sweep_phase + 1;
            if (sweep_phase >= period_cfg) begin
                grace_open = (tick_count - {1'b0, grace_cfg}) > GRACE_SPLIT;
                sweep_phase = '0;
                res.swept = 1'b1;
                sweep_count++;
                if (!grace_open) begin
                    for (int c = 0; c < CLIENTS; c++) begin
                        elapsed = tick_count - last_checkin[c];
                        if (!found && client_on[c] && elapsed >= deadline_cfg[c]) begin
                            found = 1'b1;
                            res.late_idx = CLIENT_W'(c);
                            res.late_by = elapsed - deadline_cfg[c];
                        end
                    end
                end
                if (!found) begin
                    res.pulse = 1'b1;
                    res.recover_event = !pulsing;
                    if (!pulsing) recover_count++;
                    pulsing = 1'b1;
                end else begin
                    res.late_valid = 1'b1;
                    res.stall_event = pulsing;
                    if (pulsing) stall_count++;
                    pulsing = 1'b0;
                end
            end
        end else if (it.client < CLIENTS) begin
            case (it.cmd)
                CMD_CHECKIN: begin
                    last_checkin[it.client] = tick_count;
                end
                CMD_SUSPEND: begin
                    client_on[it.client] = 1'b0;
                end
                default: begin
                    last_checkin[it.client] = tick_count;
                    client_on[it.client] = 1'b1;
                end
            endcase
        end else begin
            ignored_count++;
        end
        res.kicking = pulsing;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= 40) begin
            $display("MISMATCH at %0t ns, result %0d: %s got %0h, expected %0h",
                     $time, results_checked, what, got, want);
        end
    endtask

    task automatic check_result(t_out_item got, t_out_item want);
        if (got.swept !== want.swept) report_mismatch("swept", got.swept, want.swept);
        if (got.pulse !== want.pulse) report_mismatch("pulse", got.pulse, want.pulse);
        if (got.stall_event !== want.stall_event) begin
            report_mismatch("stall_event", got.stall_event, want.stall_event);
        end
        if (got.recover_event !== want.recover_event) begin
            report_mismatch("recover_event", got.recover_event, want.recover_event);
        end
        if (got.late_valid !== want.late_valid) begin
            report_mismatch("late_valid", got.late_valid, want.late_valid);
        end
        if (got.late_idx !== want.late_idx) begin
            report_mismatch("late_idx", got.late_idx, want.late_idx);
        end
        if (got.late_by !== want.late_by) report_mismatch("late_by", got.late_by, want.late_by);
        if (got.kicking !== want.kicking) report_mismatch("kicking", got.kicking, want.kicking);
    endtask

    always @(posedge i_clk) begin : drive_items
        logic send_now;
        send_now = i_in_valid;
        if (i_in_valid && o_in_ready) begin
            expected_gate_results.push_back(next_gate_result(i_in_item));
            items_accepted++;
            send_now = 1'b0;
        end
        if (!send_now) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (queued_cmds.size() != 0) begin
                if (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
                    send_gap = $urandom_range(18, 0);
                end else begin
                    i_in_item <= queued_cmds.pop_front();
                    send_now = 1'b1;
                end
            end
        end
        i_in_valid <= send_now;
    end

    always @(posedge i_clk) begin : watch_results
        if (o_out_valid && i_out_ready) begin
            if (expected_gate_results.size() == 0) begin
                report_mismatch("result with no item waiting", o_out_item.kicking, 0);
            end else begin
                check_result(o_out_item, expected_gate_results.pop_front());
            end
            results_checked++;
        end
        if (recv_gap > 0) begin
            recv_gap--;
            i_out_ready <= 1'b0;
        end else if (recv_idle_pct != 0 && $urandom_range(99, 0) < recv_idle_pct) begin
            recv_gap = $urandom_range(18, 0);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic write_register(t_reg_idx idx, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_DEADLINE0:    deadline_cfg[0] = value;
            REG_DEADLINE1:    deadline_cfg[1] = value;
            REG_DEADLINE2:    deadline_cfg[2] = value;
            REG_SWEEP_PERIOD: period_cfg = value[PERIOD_W-1:0];
            default:          grace_cfg = value[GRACE_W-1:0];
        endcase
    endtask

    task automatic apply_settings(logic [31:0] d0, logic [31:0] d1, logic [31:0] d2,
                                  logic [31:0] period, logic [31:0] grace);
        write_register(REG_DEADLINE0, d0);
        write_register(REG_DEADLINE1, d1);
        write_register(REG_DEADLINE2, d2);
        write_register(REG_SWEEP_PERIOD, period);
        write_register(REG_BOOT_GRACE, grace);
        settings_applied++;
    endtask

    task automatic wait_until_drained();
        do begin
            @(negedge i_clk);
        end while (queued_cmds.size() != 0 || i_in_valid || expected_gate_results.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic queue_item(t_cmd cmd, int client);
        t_in_item it;
        it.cmd = cmd;
        it.client = CLIENT_W'(client);
        queued_cmds.push_back(it);
    endtask

    function automatic t_in_item random_item();
        t_in_item it;
        int       roll;
        roll = $urandom_range(99, 0);
        if (roll < 55) it.cmd = CMD_TICK;
        else if (roll < 82) it.cmd = CMD_CHECKIN;
        else if (roll < 90) it.cmd = CMD_SUSPEND;
        else it.cmd = CMD_RESUME;
        if ($urandom_range(11, 0) == 0) it.client = CLIENT_W'(CLIENTS);
        else it.client = CLIENT_W'($urandom_range(CLIENTS - 1, 0));
        return it;
    endfunction

    function automatic logic [31:0] pick_deadline();
        case ($urandom_range(9, 0))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom();
            default: return $urandom_range(60, 1);
        endcase
    endfunction

    function automatic logic [31:0] pick_period();
        case ($urandom_range(9, 0))
            0: return 32'd0;
            1: return $urandom_range(20'hF_FFFF, 1);
            2: return $urandom_range(40, 9);
            default: return $urandom_range(8, 1);
        endcase
    endfunction

    function automatic logic [31:0] pick_grace();
        case ($urandom_range(7, 0))
            0: return 32'd0;
            1: return 32'h7FFF_FFFF;
            2: return $urandom();
            default: return tick_count + $urandom_range(150, 0);
        endcase
    endfunction

    initial begin : stimulus
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Out-of-range client commands first, then each command under reset settings.
        queue_item(CMD_CHECKIN, CLIENTS);
        queue_item(CMD_SUSPEND, CLIENTS);
        queue_item(CMD_RESUME, CLIENTS);
        queue_item(CMD_TICK, 3);
        queue_item(CMD_CHECKIN, 0);
        queue_item(CMD_SUSPEND, 1);
        queue_item(CMD_RESUME, 1);
        queue_item(CMD_TICK, 0);
        wait_until_drained();

        // A zero period sweeps on every tick, and it sits below the current phase.
        apply_settings(32'd0, 32'd3, 32'hFFFF_FFFF, 32'd0, 32'd0);
        queue_item(CMD_TICK, 0);
        queue_item(CMD_TICK, 0);
        queue_item(CMD_SUSPEND, 0);
        queue_item(CMD_TICK, 0);
        queue_item(CMD_CHECKIN, 1);
        queue_item(CMD_TICK, 0);
        queue_item(CMD_TICK, 0);
        queue_item(CMD_TICK, 0);
        queue_item(CMD_TICK, 0);
        queue_item(CMD_RESUME, 0);
        queue_item(CMD_TICK, 0);
        queue_item(CMD_SUSPEND, 0);
        queue_item(CMD_SUSPEND, 1);
        queue_item(CMD_TICK, 0);
        queue_item(CMD_SUSPEND, 2);
        queue_item(CMD_TICK, 0);
        queue_item(CMD_RESUME, 2);
        queue_item(CMD_TICK, 0);
        wait_until_drained();

        for (int phase = 0; phase < 8; phase++) begin
            if (phase == 0) begin
                apply_settings(32'd0, 32'd1, 32'd0, 32'd1, 32'd0);
            end else if (phase == 3) begin
                apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                               32'h000F_FFFF, 32'h7FFF_FFFF);
            end else begin
                apply_settings(pick_deadline(), pick_deadline(), pick_deadline(),
                               pick_period(), pick_grace());
            end
            case (phase % 3)
                0: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                1: begin
                    send_idle_pct = 8;
                    recv_idle_pct = 30;
                end
                default: begin
                    send_idle_pct = 35;
                    recv_idle_pct = 8;
                end
            endcase
            if (phase == 7) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            repeat (200) queued_cmds.push_back(random_item());
            wait_until_drained();
        end

        if (expected_gate_results.size() != 0) begin
            report_mismatch("results never delivered", expected_gate_results.size(), 0);
        end
        $display("Checked %0d results from %0d items over %0d register settings.",
                 results_checked, items_accepted, settings_applied);
        $display("Saw %0d sweeps, %0d stalls, %0d recoveries and %0d ignored client commands.",
                 sweep_count, stall_count, recover_count, ignored_count);
        if (mismatch_count == 0) begin
            $display("multi_client_watchdog_gate_top regression: pass");
        end else begin
            $display("multi_client_watchdog_gate_top regression: fail");
        end
        $finish;
    end

    initial begin : watchdog_limit
        #5_000_000;
        $display("Timed out with %0d results still expected.", expected_gate_results.size());
        $display("multi_client_watchdog_gate_top regression: fail");
        $finish;
    end

endmodule
